[hdl/ncw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ncw_pkg: shared constants and types of the nearest codeword encoder
// Sizes, command and mode codes, register indexes and the structs that run
// between the top level and the codeword cells.
// ----------------------------------------------------------------------------
package ncw_pkg;

  localparam int ENTRIES     = 64;
  localparam int MAX_LENGTH  = 8;
  localparam int SAMPLE_BITS = 16;

  localparam int ENTRY_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ELEM_BITS  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
  localparam int USED_BITS  = ENTRY_BITS + 1;
  localparam int SEEN_BITS  = $clog2(MAX_LENGTH + 2);
  localparam int SQ_BITS    = 2 * SAMPLE_BITS;
  localparam int DIST_BITS  = 40;

  // Input field widths
  localparam int IDX_W   = 6;
  localparam int ELEM_W  = 3;

  // Configuration register widths and indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_USED  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] MODE_EXACT = 2'd0;
  localparam logic [1:0] MODE_L2    = 2'd1;
  localparam logic [1:0] MODE_L1    = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Best candidate carried along the cell row during the search sweep
  typedef struct packed {
    logic                  found;
    logic [ENTRY_BITS-1:0] idx;
    logic [DIST_BITS-1:0]  score;
  } chain_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic                  load_en;
    logic [ENTRY_BITS-1:0] load_entry;
    logic [ELEM_BITS-1:0]  load_elem;
    logic                  query_en;
    logic [ELEM_BITS-1:0]  query_pos;
    logic                  clear;
    logic [1:0]            mode;
  } cell_ctl_t;

endpackage : ncw_pkg
`default_nettype wire

[hdl/ncw_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ncw_cell: one codeword cell
// Holds one codeword, its equality flag and its running distance; in the
// search sweep it merges its own candidate into the one from its neighbor.
// ----------------------------------------------------------------------------
module ncw_cell (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire  [ncw_pkg::ENTRY_BITS-1:0]        cell_id,
  input  wire  [ncw_pkg::USED_BITS-1:0]         used,
  input  wire  ncw_pkg::cell_ctl_t              ctl,
  input  wire  signed [ncw_pkg::SAMPLE_BITS-1:0] sample,
  input  wire  ncw_pkg::chain_t                 chain_in,
  output ncw_pkg::chain_t                       chain_out
);
  import ncw_pkg::*;

  logic signed [SAMPLE_BITS-1:0] word_r [MAX_LENGTH];
  logic [DIST_BITS-1:0]          dist_r, dist_nxt;
  logic                          eq_r, eq_nxt;
  chain_t                        chain_r, chain_nxt;

  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS-1:0]        mag;
  logic [SQ_BITS-1:0]            sq;
  logic                          active;
  logic                          take;

  // Codeword storage; undefined until loaded
  always_ff @(posedge clk) begin
    if (ctl.load_en && ctl.load_entry == cell_id) begin
      word_r[ctl.load_elem] <= sample;
    end
  end

  always_comb begin
    diff = {sample[SAMPLE_BITS-1], sample}
         - {word_r[ctl.query_pos][SAMPLE_BITS-1], word_r[ctl.query_pos]};
    mag  = diff[SAMPLE_BITS] ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];
    sq   = mag * mag;
  end

  always_comb begin
    dist_nxt = dist_r;
    eq_nxt   = eq_r;
    if (ctl.clear) begin
      dist_nxt = '0;
      eq_nxt   = 1'b1;
    end else if (ctl.query_en) begin
      if (diff != '0) begin
        eq_nxt = 1'b0;
      end
      case (ctl.mode)
        MODE_L2: dist_nxt = dist_r + DIST_BITS'(sq);
        MODE_L1: dist_nxt = dist_r + DIST_BITS'(mag);
        default: dist_nxt = dist_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= '0;
      eq_r   <= 1'b1;
    end else begin
      dist_r <= dist_nxt;
      eq_r   <= eq_nxt;
    end
  end

  // Merge own candidate into the incoming best; lowest index wins ties
  always_comb begin
    active = {1'b0, cell_id} < used;
    if (ctl.mode == MODE_EXACT) begin
      take = active && !chain_in.found && eq_r;
    end else begin
      take = active && (!chain_in.found || dist_r < chain_in.score);
    end
    if (take) begin
      chain_nxt.found = 1'b1;
      chain_nxt.idx   = cell_id;
      chain_nxt.score = dist_r;
    end else begin
      chain_nxt = chain_in;
    end
  end

  always_ff @(posedge clk) begin
    chain_r <= chain_nxt;
  end

  assign chain_out = chain_r;

endmodule : ncw_cell
`default_nettype wire

[hdl/nearest_codeword_encoder_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_codeword_encoder_core: vector quantizer, nearest codeword search
// Loads a codebook element by element into a row of codeword cells, streams
// query vectors through all cells at once and returns the matching or
// nearest entry for each complete query, except in match mode 3, which returns none.
// ----------------------------------------------------------------------------
//
//  channel  | ports                     | direction | beat carries
//  ---------+---------------------------+-----------+----------------------------
//  input    | in_valid / in_stall       | in        | command, indexes, sample,
//           |                           |           | last_element
//  result   | out_valid / out_stall     | out       | code_index, match_found,
//           |                           |           | status
//  config   | cfg_wr_en                 | in        | cfg_index, cfg_wr_data
//
//  A load beat or a query beat that is not the last element is taken without a stall.
//  The last element of a query starts a search sweep along the cell row: the best
//  candidate passes through each codeword cell in turn and is then loaded into the
//  result register, and the input holds stall until the sweep retires.
//  A stalled result holds the sweep at its end until the output register frees.
//  Reset is synchronous, active low; the codebook keeps no reset value.
// ----------------------------------------------------------------------------
module nearest_codeword_encoder_core (
  input  wire                                     clk,
  input  wire                                     rst_n,
  // configuration
  input  wire                                     cfg_wr_en,
  input  wire  [ncw_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire  [ncw_pkg::CFG_DATA_W-1:0]          cfg_wr_data,
  // input channel
  input  wire                                     in_valid,
  output logic                                    in_stall,
  input  wire                                     in_command,
  input  wire  [ncw_pkg::IDX_W-1:0]               in_entry_index,
  input  wire  [ncw_pkg::ELEM_W-1:0]              in_element_index,
  input  wire  signed [ncw_pkg::SAMPLE_BITS-1:0]  in_sample_value,
  input  wire                                     in_last_element,
  // result channel
  output logic                                    out_valid,
  input  wire                                     out_stall,
  output logic [ncw_pkg::IDX_W-1:0]               out_code_index,
  output logic                                    out_match_found,
  output logic                                    out_status
);
  import ncw_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;
  localparam int   CNT_BITS = $clog2(ENTRIES + 1);

  // configuration registers
  logic [1:0]             match_mode_r;
  logic [CFG_DATA_W-1:0]  entries_used_r;
  logic [3:0]             vector_length_r;

  logic                   state_r, state_nxt;
  logic [CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic [SEEN_BITS-1:0]   seen_r, seen_nxt;
  logic [1:0]             mode_l_r, mode_l_nxt;
  logic                   mismatch_r, mismatch_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]       code_r, code_nxt;
  logic                   found_r, found_nxt;
  logic                   status_r, status_nxt;

  logic                   in_fire;
  logic                   out_fire;
  logic                   is_query;
  logic                   sweep_done;
  logic                   finish;
  logic [USED_BITS-1:0]   used_c;
  logic [31:0]            ent_ext, elem_ext, pos_ext;
  cell_ctl_t              ctl;
  chain_t                 chain_w [ENTRIES];
  chain_t                 chain_first;
  chain_t                 best;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign is_query = in_command == CMD_QUERY;
  assign in_stall = state_r != ST_IDLE;

  // configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_mode_r    <= MODE_EXACT;
      entries_used_r  <= CFG_DATA_W'(64);
      vector_length_r <= 4'd8;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MATCH_MODE:    match_mode_r    <= cfg_wr_data[1:0];
        CFG_ENTRIES_USED:  entries_used_r  <= cfg_wr_data;
        CFG_VECTOR_LENGTH: vector_length_r <= cfg_wr_data[3:0];
        default: ;
      endcase
    end
  end

  // clamp the searched entry count into 1..ENTRIES
  always_comb begin
    if (entries_used_r == '0) begin
      used_c = USED_BITS'(1);
    end else if (32'(entries_used_r) > 32'(ENTRIES)) begin
      used_c = USED_BITS'(ENTRIES);
    end else begin
      used_c = USED_BITS'(entries_used_r);
    end
  end

  // broadcast control for the cell row
  always_comb begin
    ent_ext  = 32'(in_entry_index);
    elem_ext = 32'(in_element_index);
    pos_ext  = 32'(seen_r);
    ctl.load_en    = in_fire && !is_query && ent_ext < 32'(ENTRIES)
                     && elem_ext < 32'(MAX_LENGTH);
    ctl.load_entry = ent_ext[ENTRY_BITS-1:0];
    ctl.load_elem  = elem_ext[ELEM_BITS-1:0];
    ctl.query_en   = in_fire && is_query && pos_ext < 32'(MAX_LENGTH);
    ctl.query_pos  = pos_ext[ELEM_BITS-1:0];
    ctl.clear      = finish;
    ctl.mode       = (state_r == ST_SWEEP) ? mode_l_r : match_mode_r;
  end

  assign chain_first = '{found: 1'b0, idx: '0, score: '1};

  for (genvar e = 0; e < ENTRIES; e++) begin : g_cell
    if (e == 0) begin : g_head
      ncw_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_id   (ENTRY_BITS'(e)),
        .used      (used_c),
        .ctl       (ctl),
        .sample    (in_sample_value),
        .chain_in  (chain_first),
        .chain_out (chain_w[e])
      );
    end else begin : g_body
      ncw_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_id   (ENTRY_BITS'(e)),
        .used      (used_c),
        .ctl       (ctl),
        .sample    (in_sample_value),
        .chain_in  (chain_w[e-1]),
        .chain_out (chain_w[e])
      );
    end
  end

  assign best       = chain_w[ENTRIES-1];
  assign sweep_done = state_r == ST_SWEEP && cnt_r == CNT_BITS'(ENTRIES);
  // retire the sweep: no result in mode 3, else wait for a free output register
  assign finish     = sweep_done && (mode_l_r == MODE_NONE || !out_valid_r || out_stall == 1'b0);

  // query sequencing
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    seen_nxt     = seen_r;
    mode_l_nxt   = mode_l_r;
    mismatch_nxt = mismatch_r;
    if (state_r == ST_IDLE) begin
      if (in_fire && is_query) begin
        if (32'(seen_r) < 32'(MAX_LENGTH + 1)) begin
          seen_nxt = seen_r + SEEN_BITS'(1);
        end
        if (in_last_element) begin
          mismatch_nxt = vector_length_r == '0
                      || 32'(vector_length_r) > 32'(MAX_LENGTH)
                      || 32'(seen_nxt) != 32'(vector_length_r);
          mode_l_nxt   = match_mode_r;
          seen_nxt     = '0;
          cnt_nxt      = '0;
          state_nxt    = ST_SWEEP;
        end
      end
    end else begin
      if (!sweep_done) begin
        cnt_nxt = cnt_r + CNT_BITS'(1);
      end
      if (finish) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    code_nxt      = code_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    if (finish && mode_l_r != MODE_NONE) begin
      out_valid_nxt = 1'b1;
      if (mismatch_r) begin
        code_nxt   = '0;
        found_nxt  = 1'b0;
        status_nxt = 1'b1;
      end else begin
        code_nxt   = best.found ? IDX_W'(best.idx) : '0;
        found_nxt  = best.found;
        status_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      seen_r      <= '0;
      mode_l_r    <= MODE_EXACT;
      mismatch_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      seen_r      <= seen_nxt;
      mode_l_r    <= mode_l_nxt;
      mismatch_r  <= mismatch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r   <= code_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_code_index  = code_r;
  assign out_match_found = found_r;
  assign out_status      = status_r;

endmodule : nearest_codeword_encoder_core
`default_nettype wire
